/* design/serial_mouse_packet_decoder_macros.svh */
// Assertion macros shared by the mouse packet decoder modules.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef SERIAL_MOUSE_PACKET_DECODER_MACROS_SVH
`define SERIAL_MOUSE_PACKET_DECODER_MACROS_SVH
`ifndef SYNTH
`define SMPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpd: same-cycle check failed");
`define SMPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smpd: next-cycle check failed");
`else
`define SMPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SMPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/smpd_pkg.sv */
package smpd_pkg;

    // Packet buffer depth; packets are never longer than five bytes.
    localparam int MAX_PACKET_BYTES = 5;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES);

    // Depth of the queue between framing and event generation (a power of two).
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] PROTO_FIVE   = 3'd0;
    localparam logic [2:0] PROTO_THREE8 = 3'd1;
    localparam logic [2:0] PROTO_PS2    = 3'd2;
    localparam logic [2:0] PROTO_NONE   = 3'd3;
    localparam logic [2:0] PROTO_TRACK  = 3'd4;
    localparam logic [2:0] PROTO_THREE7 = 3'd5;

    localparam logic [1:0] EV_MOTION = 2'd0;
    localparam logic [1:0] EV_LEFT   = 2'd1;
    localparam logic [1:0] EV_MIDDLE = 2'd2;
    localparam logic [1:0] EV_RIGHT  = 2'd3;

    localparam logic [7:0] SYNC_MASK_FIVE   = 8'hF8;
    localparam logic [7:0] SYNC_VAL_FIVE    = 8'h80;
    localparam logic [7:0] SYNC_MASK_THREE8 = 8'hC0;
    localparam logic [7:0] SYNC_VAL_THREE8  = 8'hC0;
    localparam logic [7:0] SYNC_MASK_THREE7 = 8'h40;
    localparam logic [7:0] SYNC_VAL_THREE7  = 8'h40;
    localparam logic [7:0] SYNC_MASK_TRACK  = 8'hC0;
    localparam logic [7:0] SYNC_VAL_TRACK   = 8'h40;
    localparam logic [7:0] HEADER_MASK      = 8'hF0;
    localparam logic [7:0] HEADER_RESET     = 8'h40;

    localparam logic [2:0] BUTTONS_ALL_UP = 3'b111;
    localparam logic [2:0] BUTTONS_PS2    = 3'b000;

    typedef enum logic [1:0] {
        FMT_FIVE,
        FMT_THREE,
        FMT_PS2
    } t_fmt;

    // One decoded packet waiting for its events to be sent.
    typedef struct packed {
        t_fmt              fmt;
        logic              motion;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        logic [2:0]        changes;
        logic [2:0]        raw;
    } t_pkt;

    typedef struct packed {
        logic       en;
        logic [2:0] proto;
    } t_cfg_wr;

    // Event kind reported for raw button bit idx of a given format.
    function automatic logic [1:0] kind_of(input t_fmt fmt, input logic [1:0] idx);
        logic [1:0] k;
        k = EV_MIDDLE;
        case (fmt)
            FMT_FIVE: begin
                case (idx)
                    2'd0:    k = EV_RIGHT;
                    2'd1:    k = EV_MIDDLE;
                    default: k = EV_LEFT;
                endcase
            end
            FMT_PS2: begin
                case (idx)
                    2'd0:    k = EV_LEFT;
                    2'd1:    k = EV_RIGHT;
                    default: k = EV_MIDDLE;
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    k = EV_RIGHT;
                    2'd1:    k = EV_LEFT;
                    default: k = EV_MIDDLE;
                endcase
            end
        endcase
        return k;
    endfunction

endpackage

/* design/smpd_front.sv */
module smpd_front
    import smpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_wr    i_cfg,
    output logic [2:0] o_protocol,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_pkt       o_pkt
);

    logic [2:0]       r_proto;
    logic [POS_W-1:0] r_pos;
    logic [2:0]       r_prev_btn;
    logic             r_pend;
    logic             r_emp;
    logic [7:0]       r_prev_hdr;
    logic [7:0]       r_bytes [MAX_PACKET_BYTES];

    logic             w_accept;
    logic             w_proto_ok;
    logic [POS_W-1:0] w_len;
    logic             w_sync_ok;
    logic             w_fourth;
    logic             w_store;
    logic [POS_W-1:0] w_wpos;
    logic [POS_W-1:0] w_npos;
    logic             w_done;
    logic [7:0]       w_eff [MAX_PACKET_BYTES];
    logic             w_emp_eff;
    logic             w_track_now;
    logic             w_decode;
    logic [7:0]       w_x3;
    logic [7:0]       w_y3;
    t_pkt             w_pkt;

    assign w_accept   = i_valid && !i_full;
    assign o_ready    = !i_full;
    assign o_protocol = r_proto;

    always_comb begin
        w_proto_ok = r_proto inside {PROTO_FIVE, PROTO_THREE8, PROTO_PS2,
                                     PROTO_TRACK, PROTO_THREE7};
        w_len = (r_proto == PROTO_FIVE) ? POS_W'(5) : POS_W'(3);
        case (r_proto)
            PROTO_FIVE:   w_sync_ok = (i_byte & SYNC_MASK_FIVE) == SYNC_VAL_FIVE;
            PROTO_THREE8: w_sync_ok = (i_byte & SYNC_MASK_THREE8) == SYNC_VAL_THREE8;
            PROTO_THREE7: w_sync_ok = (i_byte & SYNC_MASK_THREE7) == SYNC_VAL_THREE7;
            PROTO_TRACK:  w_sync_ok = (i_byte & SYNC_MASK_TRACK) == SYNC_VAL_TRACK;
            default:      w_sync_ok = 1'b1;
        endcase

        // A pending trackball fourth byte is consumed instead of starting a packet.
        w_fourth = w_accept && w_proto_ok && (r_pos == '0) && (r_proto == PROTO_TRACK)
                   && r_pend;
        w_store  = w_accept && w_proto_ok && !w_fourth && ((r_pos != '0) || w_sync_ok);
        w_wpos   = (r_pos >= w_len) ? '0 : r_pos;
        w_npos   = w_wpos + POS_W'(1);
        w_done   = w_store && (w_npos >= w_len);

        for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
            w_eff[i] = (w_store && (w_wpos == POS_W'(i))) ? i_byte : r_bytes[i];
        end

        w_emp_eff   = w_fourth ? (|i_byte[7:4]) : r_emp;
        w_track_now = (w_eff[1] != '0) || (w_eff[2] != '0) || (w_eff[0] != r_prev_hdr);
        w_decode    = w_fourth || (w_done && ((r_proto != PROTO_TRACK) || w_track_now));

        w_x3 = {w_eff[0][1:0], w_eff[1][5:0]};
        w_y3 = {w_eff[0][3:2], w_eff[2][5:0]};

        case (r_proto)
            PROTO_FIVE: begin
                w_pkt.fmt = FMT_FIVE;
                w_pkt.raw = w_eff[0][2:0];
                w_pkt.dx  = signed'({w_eff[1][7], w_eff[1]}) + signed'({w_eff[3][7], w_eff[3]});
                w_pkt.dy  = signed'({w_eff[2][7], w_eff[2]}) + signed'({w_eff[4][7], w_eff[4]});
            end
            PROTO_PS2: begin
                w_pkt.fmt = FMT_PS2;
                w_pkt.raw = w_eff[0][2:0];
                w_pkt.dx  = signed'({w_eff[0][4], w_eff[1]});
                w_pkt.dy  = signed'({w_eff[0][5], w_eff[2]});
            end
            default: begin
                // Buttons are active high on the wire and inverted here; the middle one comes from the extra byte.
                w_pkt.fmt = FMT_THREE;
                w_pkt.raw = ~{w_emp_eff, w_eff[0][5], w_eff[0][4]};
                w_pkt.dx  = signed'({w_x3[7], w_x3});
                w_pkt.dy  = -signed'({w_y3[7], w_y3});
            end
        endcase
        w_pkt.changes = w_pkt.raw ^ r_prev_btn;
        w_pkt.motion  = (w_pkt.dx != '0) || (w_pkt.dy != '0);

        o_push = w_decode && (w_pkt.motion || (w_pkt.changes != '0));
        o_pkt  = w_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proto    <= PROTO_NONE;
            r_pos      <= '0;
            r_prev_btn <= BUTTONS_ALL_UP;
            r_pend     <= 1'b0;
            r_emp      <= 1'b0;
            r_prev_hdr <= HEADER_RESET;
        end else if (i_cfg.en) begin
            r_proto    <= i_cfg.proto;
            r_pos      <= '0;
            r_prev_btn <= (i_cfg.proto == PROTO_PS2) ? BUTTONS_PS2 : BUTTONS_ALL_UP;
        end else begin
            if (w_store) begin
                r_pos <= w_done ? '0 : w_npos;
            end
            if (w_fourth) begin
                r_pend <= 1'b0;
                r_emp  <= |i_byte[7:4];
            end
            if (w_done && (r_proto == PROTO_TRACK)) begin
                if (w_track_now) begin
                    r_prev_hdr <= w_eff[0] & HEADER_MASK;
                end else begin
                    r_pend <= 1'b1;
                end
            end
            if (w_decode) begin
                r_prev_btn <= w_pkt.raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_bytes[w_wpos] <= i_byte;
        end
    end

endmodule

/* design/smpd_fifo.sv */
module smpd_fifo
    import smpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_pkt o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_pkt             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* design/smpd_back.sv */
`include "serial_mouse_packet_decoder_macros.svh"

module smpd_back
    import smpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pkt_valid,
    input  t_pkt              i_pkt,
    output logic              o_pkt_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_event_kind,
    output logic signed [8:0] o_delta_x,
    output logic signed [8:0] o_delta_y,
    output logic              o_button_up,
    output logic              o_last_event
);

    logic              r_busy;
    logic [3:0]        r_rem;
    t_fmt              r_fmt;
    logic signed [8:0] r_dx;
    logic signed [8:0] r_dy;
    logic [2:0]        r_raw;
    logic              r_ov;
    logic [1:0]        r_kind;
    logic signed [8:0] r_odx;
    logic signed [8:0] r_ody;
    logic              r_up;
    logic              r_last;

    logic              w_adv;
    logic [3:0]        w_sel;
    logic [3:0]        w_rem_next;
    logic              w_last;
    logic [1:0]        w_idx;
    logic [1:0]        w_kind;
    logic signed [8:0] w_dx;
    logic signed [8:0] w_dy;
    logic              w_up;

    // Bit 0 of the remaining mask is the motion event, bits 1 to 3 the button bits.
    always_comb begin
        w_adv      = r_busy && (!r_ov || i_ready);
        w_sel      = r_rem & (~r_rem + 4'd1);
        w_rem_next = r_rem & ~w_sel;
        w_last     = (w_rem_next == '0);
        if (w_sel[1]) begin
            w_idx = 2'd0;
        end else if (w_sel[2]) begin
            w_idx = 2'd1;
        end else begin
            w_idx = 2'd2;
        end
        if (w_sel[0]) begin
            w_kind = EV_MOTION;
            w_dx   = r_dx;
            w_dy   = r_dy;
            w_up   = 1'b0;
        end else begin
            w_kind = kind_of(r_fmt, w_idx);
            w_dx   = '0;
            w_dy   = '0;
            w_up   = (r_fmt == FMT_PS2) ? ~r_raw[w_idx] : r_raw[w_idx];
        end
        o_pkt_pop = i_pkt_valid && (!r_busy || (w_adv && w_last));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_adv) begin
                r_ov  <= 1'b1;
                r_rem <= w_rem_next;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (o_pkt_pop) begin
                r_busy <= 1'b1;
                r_rem  <= {i_pkt.changes, i_pkt.motion};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_kind <= w_kind;
            r_odx  <= w_dx;
            r_ody  <= w_dy;
            r_up   <= w_up;
            r_last <= w_last;
        end
        if (o_pkt_pop) begin
            r_fmt <= i_pkt.fmt;
            r_dx  <= i_pkt.dx;
            r_dy  <= i_pkt.dy;
            r_raw <= i_pkt.raw;
        end
    end

    assign o_valid      = r_ov;
    assign o_event_kind = r_kind;
    assign o_delta_x    = r_odx;
    assign o_delta_y    = r_ody;
    assign o_button_up  = r_up;
    assign o_last_event = r_last;

    `SMPD_ASSERT_IMP(a_button_no_motion, i_clk, i_rst_n, r_ov && (r_kind != EV_MOTION), (r_odx == '0) && (r_ody == '0))
    `SMPD_ASSERT_IMP(a_motion_nonzero, i_clk, i_rst_n, r_ov && (r_kind == EV_MOTION), ((r_odx != '0) || (r_ody != '0)) && !r_up)
    `SMPD_ASSERT_IMP(a_busy_has_work, i_clk, i_rst_n, r_busy, r_rem != '0)
    `SMPD_ASSERT_NXT(a_idle_after_last, i_clk, i_rst_n, w_adv && w_last && !i_pkt_valid, !r_busy)

endmodule

/* design/serial_mouse_packet_decoder.sv */
// A packet is queued, then loaded into the event generator, which registers each event.
// Throughput: one byte per cycle while the packet queue has room; one event per cycle out
// while the consumer is ready; a packet yields at most four events.
// Reset: synchronous, active low; protocol becomes 3 (every byte dropped), framing restarts,
// the queue empties and no event is offered until bytes arrive after a protocol write.
module serial_mouse_packet_decoder
    import smpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB-style configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Received byte request channel.
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    // Event request channel.
    output logic              o_ev_valid,
    input  logic              i_ev_ready,
    output logic [1:0]        o_event_kind,
    output logic signed [8:0] o_delta_x,
    output logic signed [8:0] o_delta_y,
    output logic              o_button_up,
    output logic              o_last_event
);

    // The only register, protocol, sits at byte address 0. Word address 1 reads as zero
    // and ignores writes.
    t_cfg_wr    w_cfg;
    logic [2:0] w_protocol;
    logic       w_full;
    logic       w_push;
    t_pkt       w_push_pkt;
    logic       w_pop;
    logic       w_q_valid;
    t_pkt       w_q_pkt;

    assign pready      = 1'b1;
    assign w_cfg.en    = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign w_cfg.proto = pwdata[2:0];
    assign prdata      = (paddr[2] == 1'b0) ? {29'd0, w_protocol} : 32'd0;

    // The framing stage takes one byte per cycle while the queue has room, tracks the byte
    // position and the button history, and turns each completed packet into a single queue
    // entry carrying both deltas and the button bits that changed. Packets that would yield
    // no event are not queued at all, so the back end only ever sees work.
    smpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .o_protocol (w_protocol),
        .i_valid    (i_rx_valid),
        .o_ready    (o_rx_ready),
        .i_byte     (i_rx_byte),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_pkt      (w_push_pkt)
    );

    // The short queue lets the framing stage keep taking bytes while a packet's events
    // are still draining towards a stalled consumer.
    smpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_pkt),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_pkt)
    );

    // The event generator walks a packet's motion and button changes in order, one per
    // cycle while the consumer is ready, into a registered output, and marks the last.
    smpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt_valid  (w_q_valid),
        .i_pkt        (w_q_pkt),
        .o_pkt_pop    (w_pop),
        .o_valid      (o_ev_valid),
        .i_ready      (i_ev_ready),
        .o_event_kind (o_event_kind),
        .o_delta_x    (o_delta_x),
        .o_delta_y    (o_delta_y),
        .o_button_up  (o_button_up),
        .o_last_event (o_last_event)
    );

endmodule

/* verif/testbench.sv */
module testbench
    import smpd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // The protocol register sits at byte address zero on the configuration port.
    localparam logic [2:0] ADDR_PROTOCOL = 3'd0;

    // Protocol codes the block does not define; both must drop every byte.
    localparam logic [2:0] PROTO_SPARE_LO = 3'd6;
    localparam logic [2:0] PROTO_SPARE_HI = 3'd7;

    // Bytes of random traffic per phase, for decoding and for dropping protocols.
    localparam int BYTES_ACTIVE  = 22;
    localparam int BYTES_DROPPED = 4;

    // Drain allowance for anything still in flight once the expected queue has emptied.
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    // Three groups of six phases, one group per handshake pressure setting. Each
    // group visits every decoding protocol and one that drops everything.
    localparam int N_PHASES = 18;
    localparam logic [2:0] PHASE_PROTOCOL [N_PHASES] = '{
        PROTO_FIVE,  PROTO_THREE8,   PROTO_PS2,   PROTO_TRACK,  PROTO_THREE7, PROTO_SPARE_HI,
        PROTO_PS2,   PROTO_TRACK,    PROTO_FIVE,  PROTO_THREE7, PROTO_SPARE_LO, PROTO_THREE8,
        PROTO_TRACK, PROTO_THREE8,   PROTO_THREE7, PROTO_FIVE,  PROTO_PS2,    PROTO_NONE
    };

    // One mouse event as it leaves the block.
    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] dx;
        logic [8:0] dy;
        logic       up;
        logic       last;
    } t_mouse_event;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = ADDR_PROTOCOL;
    logic [31:0]       pwdata = 32'd0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_rx_valid = 1'b0;
    logic              o_rx_ready;
    logic [7:0]        i_rx_byte = 8'd0;
    logic              o_ev_valid;
    logic              i_ev_ready = 1'b0;
    logic [1:0]        o_event_kind;
    logic signed [8:0] o_delta_x;
    logic signed [8:0] o_delta_y;
    logic              o_button_up;
    logic              o_last_event;

    serial_mouse_packet_decoder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_ev_valid   (o_ev_valid),
        .i_ev_ready   (i_ev_ready),
        .o_event_kind (o_event_kind),
        .o_delta_x    (o_delta_x),
        .o_delta_y    (o_delta_y),
        .o_button_up  (o_button_up),
        .o_last_event (o_last_event)
    );

    always #6 i_clk = ~i_clk;

    // Bytes waiting to be offered, and the events the decoder is owed.
    logic [7:0]   pending_bytes [$];
    t_mouse_event expected_events [$];

    // Percentage of cycles in which the byte sender and the event receiver hold back.
    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 85;

    // Set at each rising edge when a byte request was taken there; the driver reads
    // it at the following falling edge to decide whether to move on.
    bit          rx_took;
    int unsigned mismatches;
    int unsigned bytes_taken;
    int unsigned events_checked;
    int unsigned cycle_count;
    t_mouse_event ev_want;

    // Header of the last trackball packet the generator believes was decoded, so that
    // it can repeat it with zero motion and so provoke the optional fourth byte.
    logic [7:0] trk_gen_header = HEADER_RESET;

    // ------------------------------------------------------------------
    // Decoder model: its own copy of the protocol register and framing state.
    // ------------------------------------------------------------------
    logic [2:0]  mdl_protocol = PROTO_NONE;
    logic [7:0]  mdl_packet [MAX_PACKET_BYTES];
    int unsigned mdl_pos = 0;
    logic [2:0]  mdl_prev_buttons = BUTTONS_ALL_UP;
    bit          mdl_fourth_pending = 1'b0;
    bit          mdl_extra_middle = 1'b0;
    logic [7:0]  mdl_prev_header = HEADER_RESET;

    function automatic int signed_byte(input logic [7:0] v);
        return int'($signed(v));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic void expect_event(input logic [1:0] kind, input int dx, input int dy,
                                         input logic up);
        t_mouse_event e;
        e.kind = kind;
        e.dx   = dx[8:0];
        e.dy   = dy[8:0];
        e.up   = up;
        e.last = 1'b0;
        expected_events.push_back(e);
    endfunction

    // Motion first when there is any, then one event per changed button in bit order.
    // kinds packs the event kind of button bit i into bits 2i+1:2i.
    function automatic void expect_packet_events(input int dx, input int dy,
                                                 input logic [2:0] raw, input logic [5:0] kinds,
                                                 input bit up_when_set);
        logic [2:0] changed;
        changed = raw ^ mdl_prev_buttons;
        if (dx != 0 || dy != 0) begin
            expect_event(EV_MOTION, dx, dy, 1'b0);
        end
        mdl_prev_buttons = raw;
        for (int i = 0; i < 3; i++) begin
            if (changed[i]) begin
                expect_event(kinds[2*i +: 2], 0, 0, up_when_set ? raw[i] : !raw[i]);
            end
        end
    endfunction

    // Three-byte and trackball layout: the top delta bits ride in the header and the
    // vertical axis is flipped. Buttons are active low once the middle bit is merged.
    function automatic void decode_three_byte();
        logic [7:0] b0;
        logic [2:0] pressed;
        logic [7:0] x8;
        logic [7:0] y8;
        b0      = mdl_packet[0];
        pressed = {mdl_extra_middle, b0[5], b0[4]};
        x8      = {b0[1:0], mdl_packet[1][5:0]};
        y8      = {b0[3:2], mdl_packet[2][5:0]};
        expect_packet_events(signed_byte(x8), -signed_byte(y8), ~pressed,
                             {EV_MIDDLE, EV_LEFT, EV_RIGHT}, 1'b1);
    endfunction

    function automatic void decode_five_byte();
        expect_packet_events(signed_byte(mdl_packet[1]) + signed_byte(mdl_packet[3]),
                             signed_byte(mdl_packet[2]) + signed_byte(mdl_packet[4]),
                             mdl_packet[0][2:0], {EV_LEFT, EV_MIDDLE, EV_RIGHT}, 1'b1);
    endfunction

    // PS/2 carries the sign of each delta as a ninth bit in the header.
    function automatic void decode_ps2();
        logic [7:0] b0;
        b0 = mdl_packet[0];
        expect_packet_events(int'(mdl_packet[1]) - (b0[4] ? 256 : 0),
                             int'(mdl_packet[2]) - (b0[5] ? 256 : 0),
                             b0[2:0], {EV_MIDDLE, EV_RIGHT, EV_LEFT}, 1'b0);
    endfunction

    function automatic void mark_last_event(input int unsigned count_before);
        t_mouse_event tail;
        if (expected_events.size() > count_before) begin
            tail      = expected_events.pop_back();
            tail.last = 1'b1;
            expected_events.push_back(tail);
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        int unsigned count_before;
        int unsigned frame_len;
        count_before = expected_events.size();
        // Codes 3, 6 and 7 swallow every byte.
        if (mdl_protocol == PROTO_NONE || mdl_protocol > PROTO_THREE7) begin
            return;
        end
        frame_len = (mdl_protocol == PROTO_FIVE) ? 5 : 3;
        if (mdl_pos == 0) begin
            if (mdl_protocol == PROTO_THREE7 && (b & SYNC_MASK_THREE7) != SYNC_VAL_THREE7) begin
                return;
            end
            if (mdl_protocol == PROTO_THREE8 && (b & SYNC_MASK_THREE8) != SYNC_VAL_THREE8) begin
                return;
            end
            if (mdl_protocol == PROTO_FIVE && (b & SYNC_MASK_FIVE) != SYNC_VAL_FIVE) begin
                return;
            end
            // A trackball fourth byte only supplies the middle button and then releases
            // the packet held back; it never opens a new packet.
            if (mdl_protocol == PROTO_TRACK && mdl_fourth_pending) begin
                mdl_fourth_pending = 1'b0;
                mdl_extra_middle   = |b[7:4];
                decode_three_byte();
                mark_last_event(count_before);
                return;
            end
            if (mdl_protocol == PROTO_TRACK && (b & SYNC_MASK_TRACK) != SYNC_VAL_TRACK) begin
                return;
            end
        end
        if (mdl_pos >= frame_len) begin
            mdl_pos = 0;
        end
        mdl_packet[mdl_pos] = b;
        mdl_pos++;
        if (mdl_pos < frame_len) begin
            return;
        end
        mdl_pos = 0;
        case (mdl_protocol)
            PROTO_FIVE: decode_five_byte();
            PROTO_PS2:  decode_ps2();
            PROTO_TRACK: begin
                // A still packet that repeats the last header may be followed by a
                // fourth byte, so it is held back until the next byte says which.
                if (mdl_packet[1] != 0 || mdl_packet[2] != 0 ||
                    mdl_packet[0] != mdl_prev_header) begin
                    decode_three_byte();
                    mdl_prev_header = mdl_packet[0] & HEADER_MASK;
                end else begin
                    mdl_fourth_pending = 1'b1;
                end
            end
            default: decode_three_byte();
        endcase
        mark_last_event(count_before);
    endfunction

    // A protocol write restarts framing and reloads the idle button state; the
    // fourth-byte flag and the middle button deliberately survive it.
    function automatic void apply_protocol(input logic [2:0] value);
        mdl_protocol     = value;
        mdl_pos          = 0;
        mdl_prev_buttons = (value == PROTO_PS2) ? BUTTONS_PS2 : BUTTONS_ALL_UP;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------
    function automatic void push_packed(input logic [63:0] bytes_msb_first, input int count);
        for (int i = count - 1; i >= 0; i--) begin
            pending_bytes.push_back(bytes_msb_first[8*i +: 8]);
        end
    endfunction

    // Mostly well-formed packets with random content, a fifth of them still, and
    // now and then a burst of random bytes to knock the framing about.
    function automatic void queue_packet(input logic [2:0] proto);
        logic [7:0] hdr;
        logic [7:0] b1;
        logic [7:0] b2;
        bit         still;
        still = ($urandom_range(4) == 0);
        if ($urandom_range(5) == 0) begin
            for (int i = $urandom_range(2); i >= 0; i--) begin
                pending_bytes.push_back(rand_byte());
            end
            return;
        end
        case (proto)
            PROTO_FIVE: begin
                pending_bytes.push_back(SYNC_VAL_FIVE | 8'($urandom_range(7)));
                for (int i = 0; i < 4; i++) begin
                    pending_bytes.push_back(still ? 8'h00 : rand_byte());
                end
            end
            PROTO_THREE8, PROTO_THREE7: begin
                hdr = rand_byte() | ((proto == PROTO_THREE8) ? SYNC_VAL_THREE8 : SYNC_VAL_THREE7);
                if (still) begin
                    hdr = hdr & 8'hF0;
                end
                pending_bytes.push_back(hdr);
                pending_bytes.push_back(still ? 8'h00 : rand_byte());
                pending_bytes.push_back(still ? 8'h00 : rand_byte());
            end
            PROTO_PS2: begin
                hdr = rand_byte();
                if (still) begin
                    hdr = hdr & 8'hCF;
                end
                pending_bytes.push_back(hdr);
                pending_bytes.push_back(still ? 8'h00 : rand_byte());
                pending_bytes.push_back(still ? 8'h00 : rand_byte());
            end
            PROTO_TRACK: begin
                if ($urandom_range(2) == 0) begin
                    // Repeat the header with no motion, then a fourth byte that presses
                    // or releases the middle button.
                    pending_bytes.push_back(trk_gen_header);
                    pending_bytes.push_back(8'h00);
                    pending_bytes.push_back(8'h00);
                    pending_bytes.push_back($urandom_range(1) ? 8'($urandom_range(15))
                                                             : rand_byte());
                end else begin
                    hdr = (rand_byte() & 8'h3F) | SYNC_VAL_TRACK;
                    if (still) begin
                        hdr = hdr & HEADER_MASK;
                    end
                    b1 = still ? 8'h00 : rand_byte();
                    b2 = still ? 8'h00 : rand_byte();
                    pending_bytes.push_back(hdr);
                    pending_bytes.push_back(b1);
                    pending_bytes.push_back(b2);
                    if (b1 != 0 || b2 != 0 || hdr != trk_gen_header) begin
                        trk_gen_header = hdr & HEADER_MASK;
                    end
                end
            end
            default: pending_bytes.push_back(rand_byte());
        endcase
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: holds a request until it is taken, otherwise offers the next
    // pending byte unless it decides to idle this cycle.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rx_valid && !rx_took) begin
            // Request still outstanding; payload stays put.
        end else if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            i_rx_byte  <= pending_bytes.pop_front();
            i_rx_valid <= 1'b1;
        end else begin
            i_rx_valid <= 1'b0;
        end
    end

    // Event receiver back-pressure.
    always @(negedge i_clk) begin
        i_ev_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: feeds taken bytes to the model first, then checks any event taken at
    // the same edge against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_took = i_rst_n && i_rx_valid && o_rx_ready;
        if (rx_took) begin
            predict_byte(i_rx_byte);
            bytes_taken++;
        end
        if (i_rst_n && o_ev_valid && i_ev_ready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event, expected none, got kind %0d dx %0d dy %0d",
                         $time, o_event_kind, o_delta_x, o_delta_y);
                mismatches++;
            end else begin
                ev_want = expected_events.pop_front();
                check_field("event_kind", ev_want.kind, o_event_kind);
                check_field("delta_x", $signed(ev_want.dx), o_delta_x);
                check_field("delta_y", $signed(ev_want.dy), o_delta_y);
                check_field("button_up", ev_want.up, o_button_up);
                check_field("last_event", ev_want.last, o_last_event);
                events_checked++;
            end
        end
    end

    // Watchdog against a hung handshake or a lost event.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Setup cycle then access cycle; the register takes the value at the edge where
    // the access cycle meets pready.
    task automatic write_protocol(input logic [2:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PROTOCOL;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_protocol(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // The block is idle once every byte has gone in and every owed event has come
    // out; a byte that caused nothing may still be in flight, hence the drain.
    task automatic wait_for_idle();
        while (pending_bytes.size() != 0 || i_rx_valid || expected_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned budget;
        logic [2:0]  proto;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Straight out of reset nothing decodes, so both extremes must vanish.
        push_packed(64'h00FF, 2);
        wait_for_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            proto = PHASE_PROTOCOL[ph];
            case (ph / 6)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 85;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_protocol(proto);

            // Directed packets in the first four phases: five-byte, eight-bit three-byte, PS/2, trackball.
            if (ph < 4) begin
                case (proto)
                    PROTO_FIVE: begin
                        // Most negative deltas with all buttons up, then most positive
                        // with all pressed, then a header that fails the sync test.
                        push_packed(64'h87_8080_8080, 5);
                        push_packed(64'h80_7F7F_7F7F_88, 6);
                    end
                    PROTO_THREE8: begin
                        // A rejected header, then left and right down with delta x -1 and delta y 1.
                        push_packed(64'h3F_FF3F3F, 4);
                    end
                    PROTO_PS2: begin
                        // Both sign bits set with zero payload, every button pressed.
                        push_packed(64'h37_0000, 3);
                    end
                    default: begin
                        // Still trackball packet repeating the reset header, so the
                        // next byte is taken as the fourth and presses the middle button.
                        push_packed(64'h40_0000_F0, 4);
                    end
                endcase
            end

            budget = pending_bytes.size() +
                     ((proto == PROTO_NONE || proto > PROTO_THREE7) ? BYTES_DROPPED
                                                                   : BYTES_ACTIVE);
            while (pending_bytes.size() < budget) begin
                queue_packet(proto);
            end
            wait_for_idle();
        end

        $display("Run covered %0d bytes across %0d protocol settings,", bytes_taken, N_PHASES);
        $display("including the unused codes; %0d events compared, %0d mismatches seen.",
                 events_checked, mismatches);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
